// ----- hdl/fabt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fabt_pkg
// Shared types and constants for the failed-attempt ban table.
// ----------------------------------------------------------------------------
package fabt_pkg;

  localparam int TABLE_ENTRIES = 32;

  localparam int ADDR_W     = 48;
  localparam int TIME_W     = 32;
  localparam int COUNT_W    = 8;
  localparam int LIMIT_W    = 8;
  localparam int MINUTES_W  = 11;
  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int BAN_MS_W   = 27;  // 2047 * 60000 fits in 27 bits

  localparam logic [15:0] MS_PER_MINUTE = 16'd60000;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // request codes
  localparam logic [1:0] REQ_CHECK = 2'd0;
  localparam logic [1:0] REQ_FAIL  = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ABUSE_LIMIT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAN_MINUTES = 1'd1;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ADDR_W-1:0] mac_address;
    logic [TIME_W-1:0] now_ms;
  } fabt_req_t;

  typedef struct packed {
    logic allowed;
    logic dropped;
  } fabt_result_t;

  // request as seen by every cell while its token runs down the chain
  typedef struct packed {
    logic [1:0]         req_type;
    logic [ADDR_W-1:0]  mac_address;
    logic [TIME_W-1:0]  now_ms;
    logic [TIME_W-1:0]  unlock_ms;
    logic [LIMIT_W-1:0] abuse_limit;
    logic               commit;
  } fabt_bcast_t;

  // token handed from cell to cell
  typedef struct packed {
    logic active;
    logic hit;
    logic free_seen;
    logic allowed;
  } fabt_tok_t;

endpackage

// ----- hdl/fabt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fabt_cell
// One table entry. Acts on the request while the token passes and hands the
// token to the next cell in the following cycle.
// ----------------------------------------------------------------------------
module fabt_cell (
  input  logic                 clk,
  input  logic                 rst,
  input  fabt_pkg::fabt_bcast_t bc,
  input  fabt_pkg::fabt_tok_t  tok_in,
  output fabt_pkg::fabt_tok_t  tok_out
);
  import fabt_pkg::*;

  logic                valid;
  logic                pend;
  logic [ADDR_W-1:0]   addr;
  logic [COUNT_W-1:0]  failures;
  logic [TIME_W-1:0]   unlock_ms;

  fabt_tok_t           tok_next;
  logic                match;
  logic                take_free;
  logic                tracking;
  logic                banned;
  logic                expired;
  logic [COUNT_W-1:0]  failures_inc;

  always_comb begin
    tracking     = (bc.abuse_limit != '0);
    match        = tok_in.active && !tok_in.hit && valid && (addr == bc.mac_address);
    take_free    = tok_in.active && !tok_in.free_seen && !valid;
    banned       = (failures >= bc.abuse_limit);
    expired      = (unlock_ms != '0) && (unlock_ms <= bc.now_ms);
    failures_inc = (failures == COUNT_MAX) ? failures : failures + 1'b1;

    tok_next = tok_in;
    if (match) begin
      tok_next.hit = 1'b1;
      if (bc.req_type == REQ_CHECK && tracking && banned && !expired) begin
        tok_next.allowed = 1'b0;
      end
    end
    if (take_free) begin
      tok_next.free_seen = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      pend    <= 1'b0;
      tok_out <= '0;
    end else begin
      tok_out <= tok_next;
      if (tok_in.active) begin
        pend <= take_free;
      end
      if (bc.commit && pend) begin
        // first free cell of a failure that found no match
        valid     <= 1'b1;
        addr      <= bc.mac_address;
        failures  <= {{(COUNT_W-1){1'b0}}, 1'b1};
        unlock_ms <= (bc.abuse_limit == {{(LIMIT_W-1){1'b0}}, 1'b1}) ? bc.unlock_ms : '0;
      end else if (match) begin
        case (bc.req_type)
          REQ_CHECK: begin
            if (tracking && banned && expired) begin
              valid <= 1'b0;
            end
          end
          REQ_FAIL: begin
            if (tracking) begin
              failures <= failures_inc;
              if (failures_inc >= bc.abuse_limit) begin
                unlock_ms <= bc.unlock_ms;
              end
            end
          end
          REQ_CLEAR: begin
            valid <= 1'b0;
          end
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// ----- hdl/failed_attempt_ban_table.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// failed_attempt_ban_table
// Lockout table of station addresses held in a chain of entry cells.
// ----------------------------------------------------------------------------
// One request at a time: start is registered into launch, the token passes
// one cell per cycle through the cell registers, and done is then registered.
// A new request may be started in the cycle that done is high.
// Reset clears all valid marks at once; limit 3, ban 30 minutes.
// The receiver cannot stall: the result word is valid only while done is high.
module failed_attempt_ban_table (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  fabt_pkg::fabt_req_t                    req,
  output logic                                   done,
  output fabt_pkg::fabt_result_t                 result,
  input  logic                                   cfg_write,
  input  logic [fabt_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [fabt_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import fabt_pkg::*;

  logic [LIMIT_W-1:0]   abuse_limit;
  logic [MINUTES_W-1:0] ban_minutes;
  logic [BAN_MS_W-1:0]  ban_ms;
  logic                 launch;
  fabt_req_t            req_r;

  fabt_bcast_t          bc;
  fabt_tok_t            tok [TABLE_ENTRIES+1];
  fabt_tok_t            tok_last;
  logic                 fail_miss;
  logic                 commit;
  logic                 drop;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      abuse_limit <= 8'd3;
      ban_minutes <= 11'd30;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_ABUSE_LIMIT: abuse_limit <= cfg_data[LIMIT_W-1:0];
        REG_BAN_MINUTES: ban_minutes <= cfg_data[MINUTES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // ban length in ms, kept up to date from the register
  always_ff @(posedge clk) begin
    ban_ms <= BAN_MS_W'({{(BAN_MS_W-MINUTES_W){1'b0}}, ban_minutes}
                        * {{(BAN_MS_W-16){1'b0}}, MS_PER_MINUTE});
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_r <= req;
    end
  end

  always_comb begin
    tok_last  = tok[TABLE_ENTRIES];
    fail_miss = tok_last.active && (req_r.req_type == REQ_FAIL)
                && (abuse_limit != '0) && !tok_last.hit;
    commit    = fail_miss && tok_last.free_seen;
    drop      = fail_miss && !tok_last.free_seen;

    bc.req_type    = req_r.req_type;
    bc.mac_address = req_r.mac_address;
    bc.now_ms      = req_r.now_ms;
    bc.unlock_ms   = req_r.now_ms + {{(TIME_W-BAN_MS_W){1'b0}}, ban_ms};
    bc.abuse_limit = abuse_limit;
    bc.commit      = commit;

    tok[0].active    = launch;
    tok[0].hit       = 1'b0;
    tok[0].free_seen = 1'b0;
    tok[0].allowed   = 1'b1;
  end

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    fabt_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .bc      (bc),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      launch <= 1'b0;
      done   <= 1'b0;
    end else begin
      launch <= start && !busy;
      done   <= tok_last.active;
      if (start && !busy) begin
        busy <= 1'b1;
      end else if (tok_last.active) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tok_last.active) begin
      result.allowed <= tok_last.allowed;
      result.dropped <= drop;
    end
  end

endmodule

// ----- dv/fabt_lockout_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fabt_lockout_checker
// Watches the request, result and register ports of the ban table, keeps its
// own copy of the lockout table, predicts each result word and compares.
// ----------------------------------------------------------------------------
module fabt_lockout_checker
  import fabt_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  busy,
  input  fabt_req_t             req,
  input  logic                  done,
  input  fabt_result_t          result,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    mismatches,
  output int                    words_pending
);

  localparam logic [LIMIT_W-1:0]   RESET_LIMIT   = 8'd3;
  localparam logic [MINUTES_W-1:0] RESET_MINUTES = 11'd30;
  localparam int                   REPORT_MAX    = 10;

  logic [LIMIT_W-1:0]   cfg_limit;
  logic [MINUTES_W-1:0] cfg_ban_min;

  logic              st_used   [TABLE_ENTRIES];
  logic [ADDR_W-1:0] st_mac    [TABLE_ENTRIES];
  logic [COUNT_W-1:0] st_count [TABLE_ENTRIES];
  logic [TIME_W-1:0] st_unlock [TABLE_ENTRIES];

  fabt_result_t outcome_q[$];
  int           bad_words;

  function automatic int find_station(logic [ADDR_W-1:0] mac);
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (st_used[i] && st_mac[i] == mac) return i;
    end
    return -1;
  endfunction

  // applies one request to the local table and returns the word it should give
  function automatic fabt_result_t apply_request(fabt_req_t r);
    fabt_result_t       res;
    int                 hit;
    int                 slot;
    logic [TIME_W-1:0]  ban_until;
    res.allowed = 1'b1;
    res.dropped = 1'b0;
    hit = find_station(r.mac_address);
    slot = -1;
    ban_until = r.now_ms + TIME_W'(cfg_ban_min) * TIME_W'(MS_PER_MINUTE);
    case (r.req_type)
      REQ_CHECK: begin
        if (cfg_limit != '0 && hit >= 0 && st_count[hit] >= cfg_limit) begin
          // unlock time zero never expires
          if (st_unlock[hit] != '0 && st_unlock[hit] <= r.now_ms) st_used[hit] = 1'b0;
          else res.allowed = 1'b0;
        end
      end
      REQ_FAIL: begin
        if (cfg_limit != '0) begin
          if (hit >= 0) begin
            if (st_count[hit] != COUNT_MAX) st_count[hit] = st_count[hit] + 1'b1;
            if (st_count[hit] >= cfg_limit) st_unlock[hit] = ban_until;
          end else begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
              if (!st_used[i]) begin
                slot = i;
                break;
              end
            end
            if (slot >= 0) begin
              st_used[slot]   = 1'b1;
              st_mac[slot]    = r.mac_address;
              st_count[slot]  = COUNT_W'(1);
              st_unlock[slot] = (cfg_limit == LIMIT_W'(1)) ? ban_until : '0;
            end else begin
              res.dropped = 1'b1;
            end
          end
        end
      end
      REQ_CLEAR: begin
        if (hit >= 0) st_used[hit] = 1'b0;
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    fabt_result_t want;
    if (rst) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) st_used[i] = 1'b0;
      cfg_limit   = RESET_LIMIT;
      cfg_ban_min = RESET_MINUTES;
      outcome_q.delete();
      bad_words = 0;
    end else begin
      // retire the finished word before taking a new request on the same edge
      if (done) begin
        if (outcome_q.size() == 0) begin
          bad_words++;
          if (bad_words <= REPORT_MAX)
            $display("%0t: result word with none outstanding: allowed=%0b dropped=%0b",
                     $realtime, result.allowed, result.dropped);
        end else begin
          want = outcome_q.pop_front();
          if (result.allowed !== want.allowed || result.dropped !== want.dropped) begin
            bad_words++;
            if (bad_words <= REPORT_MAX)
              $display("%0t: result mismatch: expected allowed=%0b dropped=%0b, got allowed=%0b dropped=%0b",
                       $realtime, want.allowed, want.dropped, result.allowed, result.dropped);
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          REG_ABUSE_LIMIT: cfg_limit   = cfg_data[LIMIT_W-1:0];
          REG_BAN_MINUTES: cfg_ban_min = cfg_data[MINUTES_W-1:0];
          default: ;
        endcase
      end
      if (start && !busy) outcome_q.push_back(apply_request(req));
    end
    words_pending <= outcome_q.size();
    mismatches    <= bad_words;
  end

endmodule

// ----- dv/failed_attempt_ban_table_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// failed_attempt_ban_table_tb
// Drives directed and random lockout requests through the ban table across
// several limit and ban-length settings; the checker beside the block
// predicts every result word and counts mismatches.
// ----------------------------------------------------------------------------
module failed_attempt_ban_table_tb;
  import fabt_pkg::*;

  localparam logic [1:0] REQ_UNUSED  = 2'd3;
  localparam int         POOL_SIZE   = 64;
  localparam int         CYCLE_LIMIT = 1000000;
  localparam int         DRAIN       = TABLE_ENTRIES + 8;

  logic                  clk = 1'b0;
  logic                  rst;
  logic                  start;
  logic                  busy;
  fabt_req_t             req;
  logic                  done;
  fabt_result_t          result;
  logic                  cfg_write;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int mismatches;
  int words_pending;
  int cycles = 0;

  logic [ADDR_W-1:0] station_pool [POOL_SIZE];
  logic [TIME_W-1:0] clock_ms;

  failed_attempt_ban_table dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .req       (req),
    .done      (done),
    .result    (result),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  fabt_lockout_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req           (req),
    .done          (done),
    .result        (result),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mismatches    (mismatches),
    .words_pending (words_pending)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("failed_attempt_ban_table verification failed");
      $finish;
    end
  end

  function automatic fabt_req_t word_of(logic [1:0] kind, logic [ADDR_W-1:0] mac,
                                        logic [TIME_W-1:0] now);
    fabt_req_t r;
    r.req_type    = kind;
    r.mac_address = mac;
    r.now_ms      = now;
    return r;
  endfunction

  // present one word and hold it until taken; start stays high unless we idle
  task automatic issue(input fabt_req_t r, input bit calm);
    int gap;
    req   <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (!calm && $urandom_range(0, 99) < 6) begin
      start <= 1'b0;
      gap = $urandom_range(1, 40);
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic settle();
    start <= 1'b0;
    while (words_pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  task automatic reconfigure(input logic [CFG_DATA_W-1:0] limit_word,
                             input logic [CFG_DATA_W-1:0] ban_word);
    settle();
    cfg_write <= 1'b1;
    cfg_index <= REG_ABUSE_LIMIT;
    cfg_data  <= limit_word;
    @(posedge clk);
    cfg_index <= REG_BAN_MINUTES;
    cfg_data  <= ban_word;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic make_request(output fabt_req_t r, input int pool_n, input int fail_pct);
    int          roll;
    logic [63:0] wide;
    roll = $urandom_range(0, 99);
    if (roll < 3)                  r.req_type = REQ_UNUSED;
    else if (roll < 15)            r.req_type = REQ_CLEAR;
    else if (roll < 15 + fail_pct) r.req_type = REQ_FAIL;
    else                           r.req_type = REQ_CHECK;
    wide = {$urandom(), $urandom()};
    if ($urandom_range(0, 99) < 5) r.mac_address = wide[ADDR_W-1:0];
    else r.mac_address = station_pool[$urandom_range(0, pool_n - 1)];
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      r.now_ms = $urandom();
    end else if (roll < 7) begin
      r.now_ms = '0;
    end else if (roll < 9) begin
      r.now_ms = {TIME_W{1'b1}} - TIME_W'($urandom_range(0, 200));
    end else begin
      clock_ms = clock_ms + TIME_W'($urandom_range(0, 30000));
      r.now_ms = clock_ms;
    end
  endtask

  task automatic run_phase(input logic [CFG_DATA_W-1:0] limit_word,
                           input logic [CFG_DATA_W-1:0] ban_word,
                           input int items, input int pool_n, input int fail_pct,
                           input bit calm);
    fabt_req_t r;
    reconfigure(limit_word, ban_word);
    for (int n = 0; n < items; n++) begin
      make_request(r, pool_n, fail_pct);
      issue(r, calm);
    end
  endtask

  initial begin
    logic [63:0]       wide;
    logic [ADDR_W-1:0] all_ones;
    logic [ADDR_W-1:0] zero_mac;
    logic [ADDR_W-1:0] odd_mac;
    rst       = 1'b1;
    start     = 1'b0;
    req       = '0;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    clock_ms  = '0;
    all_ones  = {ADDR_W{1'b1}};
    zero_mac  = '0;
    odd_mac   = 48'h8000_0000_0001;
    station_pool[0] = zero_mac;
    station_pool[1] = all_ones;
    for (int i = 2; i < POOL_SIZE; i++) begin
      wide = {$urandom(), $urandom()};
      station_pool[i] = wide[ADDR_W-1:0];
    end
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: limit 3, 30 minutes
    issue(word_of(REQ_CHECK, zero_mac, 32'd0), 1'b0);
    issue(word_of(REQ_FAIL,  all_ones, 32'd100), 1'b0);
    issue(word_of(REQ_FAIL,  all_ones, 32'd200), 1'b0);
    issue(word_of(REQ_CHECK, all_ones, 32'd250), 1'b0);        // below limit
    issue(word_of(REQ_FAIL,  all_ones, 32'd300), 1'b0);        // now banned
    issue(word_of(REQ_CHECK, all_ones, 32'd1_800_299), 1'b0);
    issue(word_of(REQ_FAIL,  all_ones, 32'd1_000), 1'b0);      // ban pushed out
    issue(word_of(REQ_CHECK, all_ones, 32'd1_800_500), 1'b0);
    issue(word_of(REQ_CHECK, all_ones, 32'hFFFF_FFFF), 1'b0);  // expired, freed
    issue(word_of(REQ_CHECK, all_ones, 32'd0), 1'b0);
    issue(word_of(REQ_UNUSED, all_ones, 32'h5A5A_A5A5), 1'b0);
    issue(word_of(REQ_CLEAR, zero_mac, 32'd7), 1'b0);          // no match
    issue(word_of(REQ_FAIL,  zero_mac, 32'hFFFF_FFFF), 1'b0);
    issue(word_of(REQ_CLEAR, zero_mac, 32'd9), 1'b0);
    // unlock time wraps past the top of the clock
    issue(word_of(REQ_FAIL,  odd_mac, 32'hFFFF_FFF0), 1'b0);
    issue(word_of(REQ_FAIL,  odd_mac, 32'hFFFF_FFF0), 1'b0);
    issue(word_of(REQ_FAIL,  odd_mac, 32'hFFFF_FFF0), 1'b0);
    issue(word_of(REQ_CHECK, odd_mac, 32'hFFFF_FFFF), 1'b0);

    // limit 1, no ban length: new entry banned at once with unlock time zero
    reconfigure(11'd1, 11'd0);
    issue(word_of(REQ_FAIL,  all_ones, 32'd0), 1'b0);
    issue(word_of(REQ_CHECK, all_ones, 32'hFFFF_FFFF), 1'b0);
    issue(word_of(REQ_CLEAR, all_ones, 32'd3), 1'b0);
    issue(word_of(REQ_CHECK, all_ones, 32'd0), 1'b0);

    // limit zero: tracking off
    reconfigure(11'd0, 11'd5);
    issue(word_of(REQ_FAIL,  zero_mac, 32'd10), 1'b0);
    issue(word_of(REQ_CHECK, zero_mac, 32'd11), 1'b0);

    run_phase(11'd3,    11'd1,    250, 48, 40, 1'b0);
    run_phase(11'd1,    11'd0,    150, 40, 40, 1'b0);
    run_phase(11'd0,    11'd1440, 100, 40, 40, 1'b0);
    // upper bits of the data word fall outside the limit register: limit 255
    run_phase(11'h7FF,  11'd2047, 300,  2, 70, 1'b0);
    run_phase(11'd2,    11'd0,    250, 36, 40, 1'b1);
    run_phase(11'd3,    11'd30,   150, 48, 40, 1'b0);

    settle();
    if (mismatches == 0 && words_pending == 0) begin
      $display("failed_attempt_ban_table verification clean");
    end else begin
      $display("failed_attempt_ban_table verification failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/fabt_pkg.sv
hdl/fabt_cell.sv
hdl/failed_attempt_ban_table.sv
dv/fabt_lockout_checker.sv
dv/failed_attempt_ban_table_tb.sv
